// ===== rtl/core/treta_pkg.sv =====
// Shared constants and types for the transfer rate / ETA estimator.
// No dependencies.
package treta_pkg;
  localparam int unsigned SlotCountDefault = 64;
  localparam int unsigned SlotW  = 6;
  localparam int unsigned ByteW  = 48;
  localparam int unsigned SpeedW = 58;

  typedef struct packed {
    logic [SlotW-1:0] slot;
    logic             restart;
    logic [ByteW-1:0] bytes;
    logic [ByteW-1:0] total;
    logic [ByteW-1:0] now;
  } item_t;
endpackage

// ===== rtl/core/transfer_rate_and_eta_estimator_core.sv =====
// Transfer rate / ETA estimator top level.
// Result path: a slot out of range goes straight to the output; otherwise up to two 64-bit
// serial divisions (rate, then ETA) and a 7-step divide by ten lie between input accept and
// result. One item at a time: the next item is taken only after the last result enters the
// output register. Two-entry input queue, one-entry output.
// Synchronous active-low reset empties the queues and marks every slot as holding no sample.
module transfer_rate_and_eta_estimator_core #(
  parameter int unsigned SLOT_COUNT = treta_pkg::SlotCountDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [5:0]  in_slot,
  input  logic        in_restart,
  input  logic [47:0] in_bytes_received,
  input  logic [47:0] in_total_bytes,
  input  logic [47:0] in_now_ms,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [5:0]  out_slot_out,
  output logic [57:0] out_avg_speed,
  output logic        out_eta_valid,
  output logic [47:0] out_eta_secs
);
  treta_pkg::item_t din, fi;
  logic avail, take, rpush;
  logic [5:0] rs; logic [57:0] rsp; logic rv; logic [47:0] re;
  assign din = '{slot: in_slot, restart: in_restart, bytes: in_bytes_received,
                 total: in_total_bytes, now: in_now_ms};

  treta_front u_front (
    .clk(clk), .rst_n(rst_n), .push(in_push), .full(in_full), .din(din),
    .avail(avail), .take(take), .dout(fi)
  );

  treta_back #(.SLOT_COUNT(SLOT_COUNT)) u_back (
    .clk(clk), .rst_n(rst_n), .avail(avail), .take(take), .item(fi),
    .res_full(!out_empty), .res_push(rpush), .res_slot(rs), .res_speed(rsp),
    .res_eta_valid(rv), .res_eta(re)
  );

  logic full_r;
  logic [5:0] s_r; logic [57:0] sp_r; logic v_r; logic [47:0] e_r;
  assign out_empty = !full_r;
  assign out_slot_out = s_r; assign out_avg_speed = sp_r;
  assign out_eta_valid = v_r; assign out_eta_secs = e_r;

  always_ff @(posedge clk) begin
    if (rpush) begin
      s_r <= rs; sp_r <= rsp; v_r <= rv; e_r <= re;
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) full_r <= 1'b0;
    else if (rpush) full_r <= 1'b1;
    else if (out_pop) full_r <= 1'b0;
  end
endmodule

// ===== rtl/core/treta_front.sv =====
// Front part: input queue of depth two between the port and the back part.
// Depends on treta_pkg.
module treta_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  treta_pkg::item_t  din,
  output logic              avail,
  input  logic              take,
  output treta_pkg::item_t  dout
);
  treta_pkg::item_t q_r [2];
  logic             wp_r, rp_r;
  logic [1:0]       cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign avail = (cnt_r != 2'd0);
  assign dout  = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push && !full) q_r[wp_r] <= din;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push && !full) wp_r <= ~wp_r;
      if (take && avail) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'((push && !full) ? 1 : 0) - 2'((take && avail) ? 1 : 0);
    end
  end
endmodule

// ===== rtl/core/treta_div.sv =====
// Restoring radix-2 divider, one quotient bit per cycle.
// No dependencies.
module treta_div #(
  parameter int unsigned W = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] num,
  input  logic [W-1:0] den,
  output logic         done,
  output logic [W-1:0] quo,
  output logic         rem_nz
);
  localparam int unsigned CW = $clog2(W + 1);
  logic [W-1:0]  q_r, d_r;
  logic [W:0]    r_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;
  logic [W:0]    trial;

  assign trial  = {r_r[W-1:0], q_r[W-1]} - {1'b0, d_r};
  assign done   = done_r;
  assign quo    = q_r;
  assign rem_nz = (r_r != '0);

  always_ff @(posedge clk) begin
    if (start) begin
      q_r <= num; d_r <= den; r_r <= '0;
    end else if (busy_r) begin
      if (!trial[W]) begin
        r_r <= trial;
        q_r <= {q_r[W-2:0], 1'b1};
      end else begin
        r_r <= {r_r[W-1:0], q_r[W-1]};
        q_r <= {q_r[W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1; cnt_r <= CW'(W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0; done_r <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== rtl/core/treta_back.sv =====
// Back part: per-slot state, rate and smoothing, ETA; one item at a time.
// Depends on treta_pkg and treta_div.
module treta_back #(
  parameter int unsigned SLOT_COUNT = treta_pkg::SlotCountDefault
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            avail,
  output logic                            take,
  input  treta_pkg::item_t                item,
  input  logic                            res_full,
  output logic                            res_push,
  output logic [treta_pkg::SlotW-1:0]     res_slot,
  output logic [treta_pkg::SpeedW-1:0]    res_speed,
  output logic                            res_eta_valid,
  output logic [treta_pkg::ByteW-1:0]     res_eta
);
  localparam int unsigned IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned BW = treta_pkg::ByteW;
  localparam int unsigned SW = treta_pkg::SpeedW;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001, S_RD   = 9'b000000010, S_CHK  = 9'b000000100,
    S_MUL  = 9'b000001000, S_DIV1 = 9'b000010000, S_SM   = 9'b000100000,
    S_DIV2 = 9'b001000000, S_ETA  = 9'b010000000, S_OUT  = 9'b100000000
  } st_t;

  st_t st_r;
  logic [BW-1:0] lb_mem [SLOT_COUNT];
  logic [BW-1:0] lt_mem [SLOT_COUNT];
  logic [SW-1:0] sp_mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] vld_r;

  treta_pkg::item_t it_r;
  logic [IW-1:0] idx;
  logic          inrange;
  logic [BW-1:0] lb_r, lt_r;
  logic [SW-1:0] osp_r, speed_r;
  logic          have_r;
  logic [63:0]   num_r, den_r;
  logic          dstart, ddone, drem;
  logic [63:0]   dquo;
  logic          div2_r;
  logic [BW-1:0] eta_r;
  logic          etav_r;
  logic [2:0]    d10_step_r;
  logic [63:0]   d10_q_r;
  logic [63:0]   d10_rem;

  assign idx     = IW'(it_r.slot);
  assign inrange = ({3'b0, it_r.slot} < 9'(SLOT_COUNT));

  treta_div #(.W(64)) u_div (
    .clk(clk), .rst_n(rst_n), .start(dstart), .num(num_r), .den(den_r),
    .done(ddone), .quo(dquo), .rem_nz(drem)
  );

  assign take          = (st_r == S_IDLE) && avail;
  assign res_push      = (st_r == S_OUT) && !res_full;
  assign res_slot      = it_r.slot;
  assign res_speed     = speed_r;
  assign res_eta_valid = etav_r;
  assign res_eta       = eta_r;

  always_comb begin
    dstart = 1'b0;
    if (st_r == S_MUL || (st_r == S_ETA && !div2_r && etav_r)) dstart = 1'b1;
  end

  // Memories: read in S_RD, written in S_CHK (no rate) or S_SM.
  always_ff @(posedge clk) begin
    if (st_r == S_RD) begin
      lb_r  <= lb_mem[idx];
      lt_r  <= lt_mem[idx];
      osp_r <= sp_mem[idx];
    end
    if (st_r == S_SM || (st_r == S_CHK && !(have_r && it_r.now > lt_r &&
        it_r.bytes >= lb_r) && inrange)) begin
      lb_mem[idx] <= it_r.bytes;
      lt_mem[idx] <= it_r.now;
      sp_mem[idx] <= (st_r == S_SM) ? speed_r : '0;
    end
  end

  logic [63:0] delta64;
  logic [63:0] sm_sum;
  assign delta64 = 64'(it_r.bytes - lb_r);
  assign sm_sum  = 64'(dquo) * 64'd3 + 64'(osp_r) * 64'd7;
  // divide by ten: estimate n*0.8/8 by shift-adds, then one correction step
  assign d10_rem = num_r - ((d10_q_r << 3) + (d10_q_r << 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; vld_r <= '0;
    end else begin
      unique case (st_r)
        S_IDLE: if (avail) begin
          it_r <= item; st_r <= S_RD;
        end
        S_RD: begin
          have_r  <= inrange && vld_r[idx] && !it_r.restart;
          speed_r <= '0; etav_r <= 1'b0; eta_r <= '0; div2_r <= 1'b0;
          st_r    <= inrange ? S_CHK : S_OUT;
        end
        S_CHK: begin
          vld_r[idx] <= 1'b1;
          if (have_r && it_r.now > lt_r && it_r.bytes >= lb_r) begin
            num_r <= delta64 * 64'd1000;
            den_r <= 64'(it_r.now - lt_r);
            st_r  <= S_MUL;
          end else st_r <= S_ETA;
        end
        S_MUL: st_r <= S_DIV1;
        S_DIV1: if (ddone) begin
          if (osp_r == '0) begin
            speed_r <= dquo[SW-1:0]; st_r <= S_SM;
          end else begin
            num_r <= sm_sum; d10_step_r <= 3'd0; st_r <= S_DIV2;
          end
        end
        S_DIV2: begin
          d10_step_r <= d10_step_r + 3'd1;
          case (d10_step_r)
            3'd0: d10_q_r <= (num_r >> 1) + (num_r >> 2);
            3'd1: d10_q_r <= d10_q_r + (d10_q_r >> 4);
            3'd2: d10_q_r <= d10_q_r + (d10_q_r >> 8);
            3'd3: d10_q_r <= d10_q_r + (d10_q_r >> 16);
            3'd4: d10_q_r <= d10_q_r + (d10_q_r >> 32);
            3'd5: d10_q_r <= d10_q_r >> 3;
            default: begin
              speed_r <= SW'(d10_q_r + 64'(d10_rem > 64'd9));
              st_r    <= S_SM;
            end
          endcase
        end
        S_SM: begin
          etav_r <= (it_r.total != '0) && (speed_r != '0);
          num_r  <= (it_r.bytes >= it_r.total) ? 64'd0 : 64'(it_r.total - it_r.bytes);
          den_r  <= 64'(speed_r);
          st_r   <= S_ETA;
        end
        S_ETA: begin
          if (!etav_r) st_r <= S_OUT;
          else if (!div2_r) div2_r <= 1'b1;
          else if (ddone) begin
            eta_r <= BW'(dquo + 64'(drem)); st_r <= S_OUT;
          end
        end
        S_OUT: if (!res_full) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
